// File: design/rgbm_pkg.sv
// Shared widths, fixed-point constants and default parameters of the RGBM HDR encoder.
// Used by the square-root lanes and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rgbm_pkg;

   localparam int CH_W   = 24;   // linear input channel width
   localparam int BYTE_W = 8;    // encoded output byte width
   localparam int H_W    = 24;   // gamma-space value, unsigned Q0.24
   localparam int RAD_W  = 2 * H_W;
   localparam int PROD_W = 2 * H_W;

   localparam int DEF_IN_FRAC_BITS = 16;
   localparam int DEF_IN_INT_BITS  = 8;

   // Fixed-point position of the radicand: sqrt(x * 2^(40 - frac)) lands in Q0.24
   localparam int RAD_POINT = 40;

   localparam logic [H_W-1:0] Q24_THRESH     = 24'd12582912;  // 0.75
   localparam logic [H_W-1:0] Q24_OFFSET_NUM = 24'd9437184;   // 0.5625
   localparam logic [H_W-1:0] Q24_OFFSET_DEN = 24'd8388608;   // 0.5
   localparam logic [H_W-1:0] Q24_ONE_M1     = 24'hFFFFFF;    // 1.0 minus one LSB

   // Channel byte: round(h * 255 * 255 / (M * 2^24)) as floor((2*h*65025 + M*2^24) / (M*2^25))
   localparam int              SCALE_W    = 17;
   localparam logic [SCALE_W-1:0] BYTE_SCALE = 17'd130050;    // 2 * 255 * 255
   localparam logic [BYTE_W-1:0]  BYTE_MULT  = 8'd255;
   localparam int P_W = H_W + SCALE_W;
   localparam int X_W = P_W + 1;
   localparam int Y_W = X_W - (H_W + 1);

endpackage

`default_nettype wire

// File: design/rgbm_delay.sv
// Enabled delay line that keeps side data in step with a pipelined unit.
// Standalone; width and depth come from the instantiating module.
`timescale 1ns / 1ps
`default_nettype none

module rgbm_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1
) (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic [WIDTH-1:0] data_in,
   output logic      [WIDTH-1:0] data_out
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= data_in;
         for (int k = 1; k < DEPTH; k++) begin
            tap_ff[k] <= tap_ff[k-1];
         end
      end
   end

   assign data_out = tap_ff[DEPTH-1];

endmodule

`default_nettype wire

// File: design/rgbm_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage.
// Requires num_hi < divisor; standalone, sizes set by the instantiating module.
`timescale 1ns / 1ps
`default_nettype none

module rgbm_div_pipe #(
   parameter int DW = 24,   // divisor and remainder width
   parameter int QW = 24    // quotient width, one stage per bit
) (
   input  wire logic          clock,
   input  wire logic          en,
   input  wire logic [DW-1:0] num_hi,
   input  wire logic [QW-1:0] num_lo,
   input  wire logic [DW-1:0] divisor,
   output logic      [QW-1:0] quotient,
   output logic      [DW-1:0] divisor_out
);

   logic [DW-1:0] rem_ff [QW];
   logic [QW-1:0] lo_ff  [QW];
   logic [QW-1:0] quo_ff [QW];
   logic [DW-1:0] div_ff [QW];
   logic [DW-1:0] rem_in [QW];
   logic [QW-1:0] lo_in  [QW];
   logic [QW-1:0] quo_in [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic [DW-1:0] rem_prev;
      logic [QW-1:0] lo_prev;
      logic [QW-1:0] quo_prev;
      logic [DW-1:0] div_prev;
      logic [DW:0]   shifted;
      logic          take;

      if (k == 0) begin : g_first
         assign rem_prev = num_hi;
         assign lo_prev  = num_lo;
         assign quo_prev = '0;
         assign div_prev = divisor;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign lo_prev  = lo_ff[k-1];
         assign quo_prev = quo_ff[k-1];
         assign div_prev = div_ff[k-1];
      end

      assign shifted = {rem_prev, lo_prev[QW-1]};
      assign take    = shifted >= {1'b0, div_prev};

      always_comb begin
         rem_in[k] = take ? DW'(shifted - {1'b0, div_prev}) : shifted[DW-1:0];
         lo_in[k]  = lo_prev << 1;
         quo_in[k] = {quo_prev[QW-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in[k];
            lo_ff[k]  <= lo_in[k];
            quo_ff[k] <= quo_in[k];
            div_ff[k] <= div_prev;
         end
      end
   end

   assign quotient    = quo_ff[QW-1];
   assign divisor_out = div_ff[QW-1];

endmodule

`default_nettype wire

// File: design/rgbm_sqrt_lane.sv
// One gamma lane: masks and scales a linear channel, then takes a truncating square root
// one result bit per stage. Depends on rgbm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rgbm_sqrt_lane #(
   parameter int IN_FRAC_BITS = rgbm_pkg::DEF_IN_FRAC_BITS,
   parameter int IN_INT_BITS  = rgbm_pkg::DEF_IN_INT_BITS
) (
   input  wire logic                      clock,
   input  wire logic                      en,
   input  wire logic [rgbm_pkg::CH_W-1:0] linear,
   output logic      [rgbm_pkg::H_W-1:0]  gamma
);
   import rgbm_pkg::*;

   localparam int IN_BITS = IN_INT_BITS + IN_FRAC_BITS;
   localparam int SHIFT   = RAD_POINT - IN_FRAC_BITS;
   localparam logic [CH_W-1:0] IN_MASK =
      (IN_BITS >= CH_W) ? {CH_W{1'b1}} : CH_W'((64'(1) << IN_BITS) - 64'(1));

   logic [RAD_W-1:0] radicand;
   logic [RAD_W-1:0] rem_ff  [H_W];
   logic [H_W-1:0]   root_ff [H_W];
   logic [RAD_W-1:0] rem_in  [H_W];
   logic [H_W-1:0]   root_in [H_W];

   assign radicand = RAD_W'(linear & IN_MASK) << SHIFT;

   for (genvar k = 0; k < H_W; k++) begin : g_stage
      localparam int B = H_W - 1 - k;
      logic [RAD_W-1:0] rem_prev;
      logic [H_W-1:0]   root_prev;
      logic [RAD_W:0]   trial;
      logic             take;

      if (k == 0) begin : g_first
         assign rem_prev  = radicand;
         assign root_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
      end

      // (root + 2^B)^2 - root^2 = root * 2^(B+1) + 2^(2B)
      assign trial = ((RAD_W + 1)'(root_prev) << (B + 1)) + ((RAD_W + 1)'(1) << (2 * B));
      assign take  = {1'b0, rem_prev} >= trial;

      always_comb begin
         rem_in[k]  = take ? RAD_W'({1'b0, rem_prev} - trial) : rem_prev;
         root_in[k] = take ? (root_prev | (H_W'(1) << B)) : root_prev;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
         end
      end
   end

   assign gamma = root_ff[H_W-1];

endmodule

`default_nettype wire

// File: design/rgbm_hdr_encoder_top.sv
// RGBM HDR encoder top level: three gamma lanes, max merge, tonemap and byte encoding.
// Depends on rgbm_pkg, rgbm_sqrt_lane, rgbm_div_pipe and rgbm_delay.
`timescale 1ns / 1ps
`default_nettype none

// Takes one linear texel per cycle while req_stall is low and returns one RGBM result per
// texel, in order. The datapath runs through four bit-serial pipelines in a row: the
// 24-stage square root in each channel lane, the 24-stage tonemap divider on the shared
// maximum, the 24-stage per-lane rescale divider and the 17-stage per-lane byte divider.
// The whole pipeline advances together; req_stall is high only while a finished result
// sits in the output register and the result side stalls it.
module rgbm_hdr_encoder_top #(
   parameter int IN_FRAC_BITS = rgbm_pkg::DEF_IN_FRAC_BITS,
   parameter int IN_INT_BITS  = rgbm_pkg::DEF_IN_INT_BITS
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [rgbm_pkg::CH_W-1:0]   req_red_linear,
   input  wire logic [rgbm_pkg::CH_W-1:0]   req_green_linear,
   input  wire logic [rgbm_pkg::CH_W-1:0]   req_blue_linear,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic      [rgbm_pkg::BYTE_W-1:0] rsp_red_byte,
   output logic      [rgbm_pkg::BYTE_W-1:0] rsp_green_byte,
   output logic      [rgbm_pkg::BYTE_W-1:0] rsp_blue_byte,
   output logic      [rgbm_pkg::BYTE_W-1:0] rsp_multiplier_byte
);
   import rgbm_pkg::*;

   localparam int LANES    = 3;
   localparam int IX_SQRT  = H_W - 1;
   localparam int IX_MERGE = IX_SQRT + 1;
   localparam int IX_TDIV  = IX_MERGE + H_W;
   localparam int IX_SCALE = IX_TDIV + 1;
   localparam int IX_DIV2  = IX_SCALE + H_W;
   localparam int IX_MULT  = IX_DIV2 + 1;
   localparam int IX_SUM   = IX_MULT + 1;
   localparam int IX_DIV3  = IX_SUM + Y_W;
   localparam int IX_OUT   = IX_DIV3 + 1;
   localparam int LAT      = IX_OUT + 1;
   localparam int SIDE_W   = LANES * H_W + H_W + 1;

   logic              en;
   logic [LAT-1:0]    valid_ff;
   logic [CH_W-1:0]   lin     [LANES];
   logic [H_W-1:0]    h_sq    [LANES];

   // merge stage
   logic [H_W-1:0]    m_in;
   logic              tm_in;
   logic [H_W-1:0]    m_ff;
   logic              tm_ff;
   logic [H_W-1:0]    hm_ff   [LANES];

   // tonemap divider and side data
   logic [H_W-1:0]    t_num;
   logic [H_W-1:0]    t_den;
   logic [H_W-1:0]    t_q;
   logic [H_W-1:0]    t_den_unused;
   logic [SIDE_W-1:0] side_in;
   logic [SIDE_W-1:0] side_out;
   logic [H_W-1:0]    h_d     [LANES];
   logic [H_W-1:0]    m_d;
   logic              tm_d;

   // rescale stage
   logic [H_W-1:0]    s_in;
   logic [PROD_W-1:0] p_ff    [LANES];
   logic [H_W-1:0]    mdiv_ff;
   logic [H_W-1:0]    mnew_ff;
   logic [H_W-1:0]    hs      [LANES];
   logic [H_W-1:0]    hs_div  [LANES];
   logic [H_W-1:0]    mnew_d;

   // multiplier byte and channel products
   logic [31:0]       msum;
   logic [BYTE_W-1:0] mb_in;
   logic [BYTE_W-1:0] mb_ff;
   logic [P_W-1:0]    pb_ff   [LANES];
   logic [X_W-1:0]    xsum    [LANES];
   logic [Y_W-1:0]    y_ff    [LANES];
   logic [BYTE_W-1:0] mb2_ff;

   // byte divider and output
   logic [Y_W-1:0]    q3      [LANES];
   logic [BYTE_W-1:0] mb3     [LANES];
   logic [BYTE_W-1:0] byte_in [LANES];
   logic [BYTE_W-1:0] rsp_red_ff;
   logic [BYTE_W-1:0] rsp_green_ff;
   logic [BYTE_W-1:0] rsp_blue_ff;
   logic [BYTE_W-1:0] rsp_mult_ff;

   // advance everything unless the output register holds a stalled result
   assign en        = !(valid_ff[IX_OUT] && rsp_stall);
   assign req_stall = !en;
   assign rsp_valid = valid_ff[IX_OUT];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[LAT-2:0], req_valid};
      end
   end

   assign lin[0] = req_red_linear;
   assign lin[1] = req_green_linear;
   assign lin[2] = req_blue_linear;

   for (genvar i = 0; i < LANES; i++) begin : g_sqrt
      rgbm_sqrt_lane #(
         .IN_FRAC_BITS(IN_FRAC_BITS),
         .IN_INT_BITS (IN_INT_BITS)
      ) u_sqrt (
         .clock (clock),
         .en    (en),
         .linear(lin[i]),
         .gamma (h_sq[i])
      );
   end

   // Merge: largest channel with a floor of one LSB, then tonemap decision
   always_comb begin
      m_in = h_sq[0];
      if (h_sq[1] > m_in) begin
         m_in = h_sq[1];
      end
      if (h_sq[2] > m_in) begin
         m_in = h_sq[2];
      end
      if (m_in == '0) begin
         m_in = H_W'(1);
      end
      tm_in = m_in > Q24_THRESH;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff  <= m_in;
         tm_ff <= tm_in;
         for (int i = 0; i < LANES; i++) begin
            hm_ff[i] <= h_sq[i];
         end
      end
   end

   // t = (m - 0.5625) / (m - 0.5); the numerator is always below the denominator
   assign t_num = tm_ff ? (m_ff - Q24_OFFSET_NUM) : '0;
   assign t_den = tm_ff ? (m_ff - Q24_OFFSET_DEN) : H_W'(1);

   rgbm_div_pipe #(
      .DW(H_W),
      .QW(H_W)
   ) u_tone_div (
      .clock      (clock),
      .en         (en),
      .num_hi     (t_num),
      .num_lo     ('0),
      .divisor    (t_den),
      .quotient   (t_q),
      .divisor_out(t_den_unused)
   );

   assign side_in = {tm_ff, m_ff, hm_ff[2], hm_ff[1], hm_ff[0]};

   rgbm_delay #(
      .WIDTH(SIDE_W),
      .DEPTH(H_W)
   ) u_side_delay (
      .clock   (clock),
      .en      (en),
      .data_in (side_in),
      .data_out(side_out)
   );

   assign h_d[0] = side_out[H_W-1:0];
   assign h_d[1] = side_out[2*H_W-1:H_W];
   assign h_d[2] = side_out[3*H_W-1:2*H_W];
   assign m_d    = side_out[4*H_W-1:3*H_W];
   assign tm_d   = side_out[SIDE_W-1];

   // Without tonemap, scale by m / m so the channel comes through unchanged
   assign s_in = tm_d ? t_q : m_d;

   always_ff @(posedge clock) begin
      if (en) begin
         mdiv_ff <= m_d;
         mnew_ff <= s_in;
         for (int i = 0; i < LANES; i++) begin
            p_ff[i] <= PROD_W'(h_d[i]) * PROD_W'(s_in);
         end
      end
   end

   for (genvar i = 0; i < LANES; i++) begin : g_rescale
      rgbm_div_pipe #(
         .DW(H_W),
         .QW(H_W)
      ) u_rescale_div (
         .clock      (clock),
         .en         (en),
         .num_hi     (p_ff[i][PROD_W-1:H_W]),
         .num_lo     (p_ff[i][H_W-1:0]),
         .divisor    (mdiv_ff),
         .quotient   (hs[i]),
         .divisor_out(hs_div[i])
      );
   end

   rgbm_delay #(
      .WIDTH(H_W),
      .DEPTH(H_W)
   ) u_m_delay (
      .clock   (clock),
      .en      (en),
      .data_in (mnew_ff),
      .data_out(mnew_d)
   );

   // M = ceil(m * 255), at least one
   always_comb begin
      msum  = 32'(mnew_d) * 32'(BYTE_MULT) + 32'(Q24_ONE_M1);
      mb_in = msum[31:H_W];
      if (mb_in == '0) begin
         mb_in = BYTE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mb_ff <= mb_in;
         for (int i = 0; i < LANES; i++) begin
            pb_ff[i] <= P_W'(hs[i]) * P_W'(BYTE_SCALE);
         end
      end
   end

   for (genvar i = 0; i < LANES; i++) begin : g_sum
      assign xsum[i] = X_W'(pb_ff[i]) + (X_W'(mb_ff) << H_W);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mb2_ff <= mb_ff;
         for (int i = 0; i < LANES; i++) begin
            y_ff[i] <= xsum[i][X_W-1:H_W+1];
         end
      end
   end

   for (genvar i = 0; i < LANES; i++) begin : g_byte
      rgbm_div_pipe #(
         .DW(BYTE_W),
         .QW(Y_W)
      ) u_byte_div (
         .clock      (clock),
         .en         (en),
         .num_hi     ('0),
         .num_lo     (y_ff[i]),
         .divisor    (mb2_ff),
         .quotient   (q3[i]),
         .divisor_out(mb3[i])
      );
      // saturate at 255
      assign byte_in[i] = (q3[i] > Y_W'({BYTE_W{1'b1}})) ? {BYTE_W{1'b1}} : q3[i][BYTE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_red_ff   <= byte_in[0];
         rsp_green_ff <= byte_in[1];
         rsp_blue_ff  <= byte_in[2];
         rsp_mult_ff  <= mb3[0];
      end
   end

   assign rsp_red_byte        = rsp_red_ff;
   assign rsp_green_byte      = rsp_green_ff;
   assign rsp_blue_byte       = rsp_blue_ff;
   assign rsp_multiplier_byte = rsp_mult_ff;

   a_merge_floor: assert property (@(posedge clock) disable iff (reset)
      valid_ff[IX_MERGE] |-> (m_ff != '0))
      else $error("merged maximum is zero");

   a_tone_range: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[IX_TDIV] && tm_d) |-> (t_q >= Q24_THRESH))
      else $error("tonemapped maximum below threshold");

   a_mult_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_multiplier_byte != '0))
      else $error("multiplier byte is zero");

endmodule

`default_nettype wire

// File: sim/rgbm_hdr_encoder_top_tb.sv
// Self-checking testbench for the RGBM HDR encoder: directed texels, then random ones,
// with random gaps on both channels. Depends on rgbm_pkg and rgbm_hdr_encoder_top.
`timescale 1ns / 1ps

module rgbm_hdr_encoder_top_tb;
   import rgbm_pkg::*;

   typedef struct packed {
      logic [BYTE_W-1:0] red;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] blue;
      logic [BYTE_W-1:0] mult;
   } rgbm_type;

   localparam int PIPE_LAT   = 94;
   localparam int STALL_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [CH_W-1:0] req_red_linear = '0;
   logic [CH_W-1:0] req_green_linear = '0;
   logic [CH_W-1:0] req_blue_linear = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [BYTE_W-1:0] rsp_red_byte, rsp_green_byte, rsp_blue_byte, rsp_multiplier_byte;

   rgbm_type expected_texels[$];
   int errors = 0;
   int texels_sent = 0;
   int results_seen = 0;
   int idle_cycles = 0;
   int stall_left = 0;
   bit stall_enable = 1'b1;

   rgbm_hdr_encoder_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_red_linear(req_red_linear), .req_green_linear(req_green_linear),
      .req_blue_linear(req_blue_linear),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_red_byte(rsp_red_byte), .rsp_green_byte(rsp_green_byte),
      .rsp_blue_byte(rsp_blue_byte), .rsp_multiplier_byte(rsp_multiplier_byte)
   );

   always #5 clock = ~clock;

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic logic [BYTE_W-1:0] scaled_byte(logic [63:0] h, logic [63:0] mult);
      logic [63:0] den, v;
      den = mult << 24;
      v = (2 * h * 65025 + den) / (2 * den);
      return (v > 255) ? 8'd255 : v[7:0];
   endfunction

   function automatic rgbm_type encode_texel(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                             logic [CH_W-1:0] b);
      logic [63:0] h[3];
      logic [63:0] m, t, mult;
      rgbm_type o;
      h[0] = int_sqrt(64'(r) << (RAD_POINT - DEF_IN_FRAC_BITS));
      h[1] = int_sqrt(64'(g) << (RAD_POINT - DEF_IN_FRAC_BITS));
      h[2] = int_sqrt(64'(b) << (RAD_POINT - DEF_IN_FRAC_BITS));
      m = h[0];
      if (h[1] > m) m = h[1];
      if (h[2] > m) m = h[2];
      if (m < 1) m = 1;
      if (m > 64'(Q24_THRESH)) begin
         t = ((m - 64'(Q24_OFFSET_NUM)) << 24) / (m - 64'(Q24_OFFSET_DEN));
         for (int i = 0; i < 3; i++) h[i] = (h[i] * t) / m;
         m = t;
      end
      mult = (m * 255 + (64'd1 << 24) - 1) >> 24;
      if (mult < 1) mult = 1;
      if (mult > 255) mult = 255;
      o.red = scaled_byte(h[0], mult);
      o.green = scaled_byte(h[1], mult);
      o.blue = scaled_byte(h[2], mult);
      o.mult = mult[7:0];
      return o;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH result %0d %s: got %0d expected %0d", results_seen, what, got, want);
      errors++;
   endtask

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Send one texel: hold it until the transfer, then idle a random gap if with_gap is set.
   task automatic send_texel(logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b,
                             bit with_gap);
      int gap;
      req_valid <= 1'b1;
      req_red_linear <= r;
      req_green_linear <= g;
      req_blue_linear <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_texels.push_back(encode_texel(r, g, b));
      texels_sent++;
      gap = with_gap ? gap_len() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic end_burst();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain_results();
      while (expected_texels.size() != 0) @(posedge clock);
   endtask

   // Check each result transfer against the oldest expectation.
   always @(posedge clock) begin
      rgbm_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_texels.size() == 0) begin
            $display("UNEXPECTED result %0d", results_seen);
            errors++;
         end else begin
            want = expected_texels.pop_front();
            if (rsp_red_byte !== want.red) report_mismatch("red", rsp_red_byte, want.red);
            if (rsp_green_byte !== want.green)
               report_mismatch("green", rsp_green_byte, want.green);
            if (rsp_blue_byte !== want.blue) report_mismatch("blue", rsp_blue_byte, want.blue);
            if (rsp_multiplier_byte !== want.mult)
               report_mismatch("multiplier", rsp_multiplier_byte, want.mult);
         end
         results_seen++;
      end
   end

   // Receiver stalls: mostly short bursts, a few long ones, some stretches with none.
   always @(posedge clock) begin
      int p;
      p = $urandom_range(0, 99);
      if (!stall_enable) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (p < 70) begin
         rsp_stall <= 1'b0;
      end else if (p < 98) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(10, 60);
      end
   end

   // Watchdog on cycles with no transfer on either side.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic test_extremes();
      send_texel(24'h000000, 24'h000000, 24'h000000, 1'b1);
      send_texel(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
      send_texel(24'hFFFFFF, 24'h000000, 24'h000000, 1'b1);
      send_texel(24'h000000, 24'hFFFFFF, 24'h000000, 1'b1);
      send_texel(24'h000000, 24'h000000, 24'hFFFFFF, 1'b1);
      send_texel(24'h000001, 24'h000000, 24'h000000, 1'b1);
      send_texel(24'hAAAAAA, 24'h555555, 24'hAAAAAA, 1'b1);
      send_texel(24'h555555, 24'hAAAAAA, 24'h555555, 1'b1);
      send_texel(24'h010000, 24'h008000, 24'h000100, 1'b1);
      end_burst();
   endtask

   // Tonemap threshold: sqrt(x)/16 = 0.75 exactly at x = 144.0 in Q8.16.
   task automatic test_threshold();
      send_texel(24'h900000, 24'h000000, 24'h000000, 1'b1);
      send_texel(24'h900001, 24'h000000, 24'h000000, 1'b1);
      send_texel(24'h8FFFFF, 24'h123456, 24'h000000, 1'b1);
      send_texel(24'h400000, 24'h900000, 24'h8FFFFF, 1'b1);
      send_texel(24'h100000, 24'h240000, 24'h910000, 1'b1);
      send_texel(24'h000003, 24'h000002, 24'h000001, 1'b1);
      end_burst();
   endtask

   // Hold off the sender until every result is back, then a full-rate burst.
   task automatic test_full_rate();
      drain_results();
      stall_enable = 1'b0;
      for (int i = 0; i < 40; i++)
         send_texel(24'($urandom()), 24'($urandom()), 24'($urandom()), 1'b0);
      end_burst();
      drain_results();
      stall_enable = 1'b1;
   endtask

   task automatic test_random(int count);
      logic [CH_W-1:0] ch[3];
      for (int i = 0; i < count; i++) begin
         for (int c = 0; c < 3; c++) begin
            case ($urandom_range(0, 4))
               0: ch[c] = 24'($urandom());
               1: ch[c] = 24'($urandom_range(0, 255));
               2: ch[c] = 24'($urandom_range(24'h880000, 24'h980000));
               3: ch[c] = 24'($urandom()) >> $urandom_range(0, 23);
               default: ch[c] = 24'($urandom_range(24'hF00000, 24'hFFFFFF));
            endcase
         end
         send_texel(ch[0], ch[1], ch[2], 1'b1);
      end
      end_burst();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_threshold();
      test_full_rate();
      test_random(600);
      drain_results();
      repeat (PIPE_LAT + 20) @(posedge clock);
      $display("Sent %0d texels (extremes, tonemap threshold, full-rate burst, random);",
               texels_sent);
      $display("checked %0d results under random gaps and stalls.", results_seen);
      if (errors == 0 && expected_texels.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
